/* src/pattern_repeat_decoder_macros.svh */
// ----------------------------------------------------------------------------
// Pattern Repeat Decoder Assertion Macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PATTERN_REPEAT_DECODER_MACROS_SVH
`define PATTERN_REPEAT_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PRD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pattern_repeat_decoder: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define PRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pattern_repeat_decoder: next-cycle check failed");

`endif

/* src/prd_pkg.sv */
// ----------------------------------------------------------------------------
// Pattern Repeat Decoder Package
// Widths and the record handoff type shared by the decoder modules.
// ----------------------------------------------------------------------------
package prd_pkg;

   localparam int BYTE_W    = 8;
   localparam int NIB_W     = 4;
   localparam int PAT_DEPTH = 15;
   localparam int LOW_BYTES = 8;
   localparam int LOW_W     = LOW_BYTES * BYTE_W;
   localparam int HIGH_W    = (PAT_DEPTH - LOW_BYTES) * BYTE_W;

   // One finished record, handed from the parser to the copy emitter
   typedef struct packed {
      logic              valid;
      logic [LOW_W-1:0]  pattern_low;
      logic [HIGH_W-1:0] pattern_high;
      logic [NIB_W-1:0]  length;
      logic [NIB_W-1:0]  repeats;
   } record_type;

endpackage

/* src/prd_frontend.sv */
// ----------------------------------------------------------------------------
// Pattern Repeat Decoder Front End
// Parses header and literal bytes, holds the pattern store and packs the
// finished pattern when the last literal of a record arrives.
// ----------------------------------------------------------------------------
module prd_frontend (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [prd_pkg::BYTE_W-1:0] req_in_byte,
   input  logic                       load_ready,
   output prd_pkg::record_type        rec
);

   logic                       in_literals_ff, in_literals_in;
   logic [prd_pkg::NIB_W-1:0]  length_ff, length_in;
   logic [prd_pkg::NIB_W-1:0]  repeat_ff, repeat_in;
   logic [prd_pkg::NIB_W-1:0]  seen_ff, seen_in;
   logic [prd_pkg::BYTE_W-1:0] store_ff [prd_pkg::PAT_DEPTH];
   logic [prd_pkg::BYTE_W-1:0] store_in [prd_pkg::PAT_DEPTH];
   logic [prd_pkg::BYTE_W-1:0] pat_byte [prd_pkg::PAT_DEPTH];
   logic [prd_pkg::NIB_W-1:0]  seen_next;
   logic                       completes;
   logic                       accept;

   // The next literal closes the record; it needs the emitter free
   assign seen_next = seen_ff + prd_pkg::NIB_W'(1);
   assign completes = in_literals_ff && (seen_next == length_ff);
   assign req_ready = !completes || load_ready;
   assign accept    = req_valid && req_ready;

   // Header / literal parsing
   always_comb begin
      in_literals_in = in_literals_ff;
      length_in      = length_ff;
      repeat_in      = repeat_ff;
      seen_in        = seen_ff;
      if (accept) begin
         if (!in_literals_ff) begin
            repeat_in      = req_in_byte[prd_pkg::NIB_W-1:0];
            length_in      = req_in_byte[prd_pkg::BYTE_W-1:prd_pkg::NIB_W];
            seen_in        = '0;
            in_literals_in = (req_in_byte[prd_pkg::BYTE_W-1:prd_pkg::NIB_W] != '0);
         end else begin
            seen_in = seen_next;
            if (completes) begin
               in_literals_in = 1'b0;
            end
         end
      end
   end

   // Pattern store write and the packed view with the incoming literal
   always_comb begin
      for (int i = 0; i < prd_pkg::PAT_DEPTH; i++) begin
         store_in[i] = store_ff[i];
         if (accept && in_literals_ff && (seen_ff == prd_pkg::NIB_W'(i))) begin
            store_in[i] = req_in_byte;
         end
         if (prd_pkg::NIB_W'(i) >= length_ff) begin
            pat_byte[i] = '0;
         end else if (seen_ff == prd_pkg::NIB_W'(i)) begin
            pat_byte[i] = req_in_byte;
         end else begin
            pat_byte[i] = store_ff[i];
         end
      end
   end

   // Record handoff
   always_comb begin
      rec.valid   = accept && completes && (repeat_ff != '0);
      rec.length  = length_ff;
      rec.repeats = repeat_ff;
      for (int i = 0; i < prd_pkg::LOW_BYTES; i++) begin
         rec.pattern_low[i*prd_pkg::BYTE_W +: prd_pkg::BYTE_W] = pat_byte[i];
      end
      for (int i = prd_pkg::LOW_BYTES; i < prd_pkg::PAT_DEPTH; i++) begin
         rec.pattern_high[(i-prd_pkg::LOW_BYTES)*prd_pkg::BYTE_W +: prd_pkg::BYTE_W] =
            pat_byte[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_literals_ff <= 1'b0;
         length_ff      <= '0;
         repeat_ff      <= '0;
         seen_ff        <= '0;
      end else begin
         in_literals_ff <= in_literals_in;
         length_ff      <= length_in;
         repeat_ff      <= repeat_in;
         seen_ff        <= seen_in;
      end
   end

   // Payload storage, no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < prd_pkg::PAT_DEPTH; i++) begin
         store_ff[i] <= store_in[i];
      end
   end

endmodule

/* src/prd_emitter.sv */
// ----------------------------------------------------------------------------
// Pattern Repeat Decoder Emitter
// Result register that presents one copy of the record per transaction and
// counts the remaining copies down.
// ----------------------------------------------------------------------------
module prd_emitter (
   input  logic                       clock,
   input  logic                       reset,
   input  prd_pkg::record_type        rec,
   output logic                       load_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [prd_pkg::LOW_W-1:0]  rsp_pattern_low,
   output logic [prd_pkg::HIGH_W-1:0] rsp_pattern_high,
   output logic [prd_pkg::NIB_W-1:0]  rsp_byte_count,
   output logic                       rsp_last_copy
);

   logic                       valid_ff, valid_in;
   logic [prd_pkg::NIB_W-1:0]  remain_ff, remain_in;
   logic [prd_pkg::LOW_W-1:0]  low_ff, low_in;
   logic [prd_pkg::HIGH_W-1:0] high_ff, high_in;
   logic [prd_pkg::NIB_W-1:0]  count_ff, count_in;
   logic                       last;
   logic                       take;

   assign last       = (remain_ff == prd_pkg::NIB_W'(1));
   assign take       = valid_ff && rsp_ready;
   assign load_ready = !valid_ff || (rsp_ready && last);

   // Load a new record or step to the next copy
   always_comb begin
      valid_in  = valid_ff;
      remain_in = remain_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      count_in  = count_ff;
      if (rec.valid) begin
         valid_in  = 1'b1;
         remain_in = rec.repeats;
         low_in    = rec.pattern_low;
         high_in   = rec.pattern_high;
         count_in  = rec.length;
      end else if (take) begin
         remain_in = remain_ff - prd_pkg::NIB_W'(1);
         valid_in  = !last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         remain_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff   <= low_in;
      high_ff  <= high_in;
      count_ff <= count_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_pattern_low  = low_ff;
   assign rsp_pattern_high = high_ff;
   assign rsp_byte_count   = count_ff;
   assign rsp_last_copy    = last;

endmodule

/* src/pattern_repeat_decoder.sv */
// ----------------------------------------------------------------------------
// Pattern Repeat Decoder
// Run-length decoder for a stream of header + literal records.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one compressed byte per transaction. A header byte holds
//   the repeat count (low nibble) and pattern length (high nibble); that many
//   literal bytes follow. Headers and literals are taken one per cycle outside the stall below.
//   rsp_* carries one copy of the pattern per transaction, up to 15 bytes
//   split over rsp_pattern_low / rsp_pattern_high, with unused bytes zero,
//   rsp_byte_count valid bytes, and rsp_last_copy on the final copy.
//   Latency: the first copy is presented the cycle after the last literal is
//   accepted; further copies follow one per cycle while rsp_ready is high.
//   Throughput: one input byte per cycle. The only stall is on a record's
//   last literal while the result register holds a copy that is not the
//   previous record's final one leaving in that same cycle; that single
//   result register sets the limit. Records with length or repeat zero emit
//   nothing. Reset (synchronous) returns the parser to expecting a header
//   and drops any pending copies. A stalled receiver holds the current copy.
// ----------------------------------------------------------------------------
`include "pattern_repeat_decoder_macros.svh"

module pattern_repeat_decoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [prd_pkg::BYTE_W-1:0] req_in_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [prd_pkg::LOW_W-1:0]  rsp_pattern_low,
   output logic [prd_pkg::HIGH_W-1:0] rsp_pattern_high,
   output logic [prd_pkg::NIB_W-1:0]  rsp_byte_count,
   output logic                       rsp_last_copy
);

   prd_pkg::record_type rec;
   logic                load_ready;

   // Header / literal parser and pattern store
   prd_frontend u_frontend (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .load_ready  (load_ready),
      .rec         (rec)
   );

   // Copy emitter
   prd_emitter u_emitter (
      .clock            (clock),
      .reset            (reset),
      .rec              (rec),
      .load_ready       (load_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pattern_low  (rsp_pattern_low),
      .rsp_pattern_high (rsp_pattern_high),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_last_copy    (rsp_last_copy)
   );

   // Checks
   `PRD_ASSERT_SAME(a_no_load_when_busy, clock, reset, !load_ready, !rec.valid)
   `PRD_ASSERT_SAME(a_count_nonzero, clock, reset, rsp_valid, rsp_byte_count != '0)
   `PRD_ASSERT_SAME(a_high_masked, clock, reset,
      rsp_valid && (rsp_byte_count <= 4'd8), rsp_pattern_high == '0)
   `PRD_ASSERT_NEXT(a_copy_repeats, clock, reset,
      rsp_valid && rsp_ready && !rsp_last_copy,
      rsp_valid && $stable(rsp_pattern_low) && $stable(rsp_byte_count))

endmodule
